@@ rtl/gray_convert_box_downscale_unit_defines.svh @@
// assertion macros shared by the gray convert and box downscale rtl
// expects a clock named clk and an active high reset named rst in scope
`ifndef GRAY_CONVERT_BOX_DOWNSCALE_UNIT_DEFINES_SVH
`define GRAY_CONVERT_BOX_DOWNSCALE_UNIT_DEFINES_SVH

// same-cycle implication
`define GCBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GCBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gcbd_pkg.sv @@
// types, sizes and helper functions for the gray convert and box downscale block
// no dependencies; used by gcbd_line_buf and the top level
package gcbd_pkg;

  // largest supported row length and frame height
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // fixed width of the size registers
  localparam int SIZE_W = 13;

  // counter and line buffer geometry
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PAIR_DEPTH = MAX_WIDTH / 2;
  localparam int SLOT_W     = $clog2(PAIR_DEPTH);
  localparam int CMP_W      = ((COL_W + 1) > SIZE_W) ? (COL_W + 1) : SIZE_W;
  localparam int RCMP_W     = ((ROW_W + 1) > SIZE_W) ? (ROW_W + 1) : SIZE_W;

  // reciprocal of three for sums up to 765
  localparam logic [9:0] RECIP3 = 10'd683;
  localparam int RECIP3_SHIFT = 11;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_COLOR_INPUT  = 2'd2
  } cfg_reg_t;

  // input request
  typedef struct packed {
    logic [7:0] red_sample;
    logic [7:0] green_sample;
    logic [7:0] blue_sample;
  } pixel_t;

  // output request
  typedef struct packed {
    logic [7:0] gray_out;
    logic       last_of_frame;
  } result_t;

  // line buffer access, one port, read and write never together
  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [SLOT_W-1:0] addr;
    logic [8:0]        data;
  } lb_req_t;

  // truncated (r+g+b)/3 via reciprocal multiply, or red when mono
  function automatic logic [7:0] gray_of(input pixel_t px, input logic color);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = 10'(px.red_sample) + 10'(px.green_sample) + 10'(px.blue_sample);
    prod = sum * RECIP3;
    return color ? prod[RECIP3_SHIFT +: 8] : px.red_sample;
  endfunction

endpackage

@@ rtl/gcbd_line_buf.sv @@
// line buffer holding the pair sums of the last even row
// depends on gcbd_pkg for geometry and the access struct
module gcbd_line_buf (
  input  logic            clk,
  input  gcbd_pkg::lb_req_t req,
  output logic [8:0]      rdata
);
  import gcbd_pkg::*;

  logic [8:0] mem [PAIR_DEPTH];

  // synchronous write and registered read
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.data;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

@@ rtl/gray_convert_box_downscale_unit.sv @@
// top level of the gray convert and 2x2 box downscale block
// depends on gcbd_pkg, gcbd_line_buf and the assertion macro header
//
// Usage:
// - pixels enter in raster order on pixel/pixel_valid/pixel_ready; one request
//   is taken per cycle while the result side keeps up
// - results leave on result/result_valid/result_ready, one for each odd row
//   and odd column; last_of_frame marks the final result of a frame
// - the pixel closing a 2x2 block is registered in stage one, alongside the
//   line buffer read, and then in the output register that drives result_valid
// - throughput is one pixel per cycle while the result side keeps up, set by the
//   single line buffer port, which is read on odd rows and written on even rows
// - a stalled result holds the two-stage pipeline; pixel_ready then follows
//   result_ready so no pixel is taken that cannot move on
// - cfg_write/cfg_index/cfg_data set width, height and colour mode; write
//   them only while the block is idle
// - reset clears the counters and the pipeline and loads 640x480 colour;
//   the line buffer needs no clearing, since each even row writes it before
//   the odd row after it reads it
`include "gray_convert_box_downscale_unit_defines.svh"
module gray_convert_box_downscale_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  gcbd_pkg::pixel_t              pixel,
  output logic                          result_valid,
  input  logic                          result_ready,
  output gcbd_pkg::result_t             result,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [gcbd_pkg::SIZE_W-1:0]   cfg_data
);
  import gcbd_pkg::*;

  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic              color_input;

  logic [COL_W-1:0]  column_index, column_index_next;
  logic [ROW_W-1:0]  row_index, row_index_next;
  logic [7:0]        pair_sum;

  logic [CMP_W-1:0]  w_eff, col_pre, col_inc, last_col;
  logic [RCMP_W-1:0] h_eff, row_inc, row_pre, row_post, last_row;
  logic [COL_W-1:0]  col_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [7:0]        gray;
  logic [8:0]        pair;

  logic              advance, accept;
  lb_req_t           lb_req;
  logic [8:0]        lb_rdata;

  logic              s1_emit, s1_last;
  logic [8:0]        s1_pair;
  logic [9:0]        total;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_W'(640);
      image_height <= SIZE_W'(480);
      color_input  <= 1'b1;
    end else if (cfg_write) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end else if (cfg_index == REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end else if (cfg_index == REG_COLOR_INPUT) begin
        color_input <= cfg_data[0];
      end
    end
  end

  // clamped frame size
  always_comb begin
    priority if (image_width == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(image_width) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(image_width);
    end
    priority if (image_height == '0) begin
      h_eff = RCMP_W'(1);
    end else if (RCMP_W'(image_height) > RCMP_W'(MAX_HEIGHT)) begin
      h_eff = RCMP_W'(MAX_HEIGHT);
    end else begin
      h_eff = RCMP_W'(image_height);
    end
    last_col = (w_eff & ~CMP_W'(1)) - CMP_W'(1);
    last_row = (h_eff & ~RCMP_W'(1)) - RCMP_W'(1);
  end

  // position of this pixel, with wrap after a size change, and of the next
  always_comb begin
    if (CMP_W'(column_index) >= w_eff) begin
      col_pre = '0;
      row_inc = RCMP_W'(row_index) + RCMP_W'(1);
    end else begin
      col_pre = CMP_W'(column_index);
      row_inc = RCMP_W'(row_index);
    end
    row_pre = (row_inc >= h_eff) ? '0 : row_inc;
    col_cur = col_pre[COL_W-1:0];
    row_cur = row_pre[ROW_W-1:0];

    col_inc  = col_pre + CMP_W'(1);
    row_post = row_pre + RCMP_W'(1);
    if (col_inc >= w_eff) begin
      column_index_next = '0;
      row_index_next    = (row_post >= h_eff) ? '0 : row_post[ROW_W-1:0];
    end else begin
      column_index_next = col_inc[COL_W-1:0];
      row_index_next    = row_cur;
    end
  end

  // gray value and horizontal pair sum
  assign gray = gray_of(pixel, color_input);
  assign pair = 9'(pair_sum) + 9'(gray);

  // pipeline moves when the output register is free or drains
  assign advance     = !result_valid || result_ready;
  assign pixel_ready = advance;
  assign accept      = pixel_valid && pixel_ready;

  // line buffer access: even rows store, odd rows fetch
  always_comb begin
    lb_req.addr = col_cur[COL_W-1:1];
    lb_req.data = pair;
    lb_req.wr   = accept && col_cur[0] && !row_cur[0];
    lb_req.rd   = accept && col_cur[0] && row_cur[0];
  end

  gcbd_line_buf u_line_buf (
    .clk   (clk),
    .req   (lb_req),
    .rdata (lb_rdata)
  );

  // counters and pending even-column gray
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
      pair_sum     <= '0;
    end else if (accept) begin
      column_index <= column_index_next;
      row_index    <= row_index_next;
      if (!col_cur[0]) begin
        pair_sum <= gray;
      end
    end
  end

  // stage one: waits for the line buffer read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_emit <= 1'b0;
    end else if (advance) begin
      s1_emit <= lb_req.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pair <= pair;
      s1_last <= (CMP_W'(col_cur) == last_col) && (RCMP_W'(row_cur) == last_row);
    end
  end

  // output register: quarter of the 2x2 sum
  assign total = 10'(lb_rdata) + 10'(s1_pair);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_emit) begin
      result.gray_out      <= total[9:2];
      result.last_of_frame <= s1_last;
    end
  end

  // checks
  `GCBD_ASSERT_NOW(a_lb_one_access, 1'b1, !(lb_req.wr && lb_req.rd), "line buffer port clash")
  `GCBD_ASSERT_NOW(a_ready_when_empty, !result_valid, pixel_ready, "pixel held with empty output")
  `GCBD_ASSERT_NEXT(a_emit_reaches_out, s1_emit && advance, result_valid, "pending result lost")
  `GCBD_ASSERT_NEXT(a_col_in_range, accept && !cfg_write, CMP_W'(column_index) < w_eff, "column past width")

endmodule
